>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge out of reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

>>> hw/rtl/tmws_pkg.sv
// ----------------------------------------------------------------------------
// tmws_pkg
// Shared types, field widths and constants of the template window search.
// ----------------------------------------------------------------------------
package tmws_pkg;

  // field widths
  localparam int CMD_W      = 2;
  localparam int PIX_W      = 9;
  localparam int COLOR_W    = 24;
  localparam int COORD_W    = 11;
  localparam int SCORE_W    = 16;
  localparam int OPAQUE_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // default store and window limits
  localparam int BG_MAX_WIDTH_DEF    = 512;
  localparam int BG_MAX_HEIGHT_DEF   = 512;
  localparam int TMPL_MAX_WIDTH_DEF  = 128;
  localparam int TMPL_MAX_HEIGHT_DEF = 128;
  localparam int WINDOW_MAX_DEF      = 64;

  // transparent key color and saturation limits
  localparam logic [COLOR_W-1:0]  CYAN_KEY   = 24'h00ffff;
  localparam logic [SCORE_W-1:0]  SCORE_MAX  = 16'hffff;
  localparam logic [OPAQUE_W-1:0] OPAQUE_MAX = 15'h7fff;

  // register reset values
  localparam logic [3:0] STRIDE_RST = 4'd5;
  localparam logic [6:0] SEARCH_RST = 7'd16;
  localparam logic [7:0] TMPL_W_RST = 8'd128;
  localparam logic [7:0] TMPL_H_RST = 8'd128;
  localparam logic [9:0] BG_W_RST   = 10'd512;
  localparam logic [9:0] BG_H_RST   = 10'd512;

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_BG   = 2'd0,
    CMD_LOAD_TMPL = 2'd1,
    CMD_SEARCH    = 2'd2
  } cmd_e;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIDE = 3'd0,
    REG_SEARCH = 3'd1,
    REG_ORG_X  = 3'd2,
    REG_ORG_Y  = 3'd3,
    REG_TMPL_W = 3'd4,
    REG_TMPL_H = 3'd5,
    REG_BG_W   = 3'd6,
    REG_BG_H   = 3'd7
  } reg_e;

  typedef struct packed {
    logic [3:0]        stride;
    logic [6:0]        search_size;
    logic signed [9:0] origin_x;
    logic signed [9:0] origin_y;
    logic [7:0]        tmpl_w;
    logic [7:0]        tmpl_h;
    logic [9:0]        bg_w;
    logic [9:0]        bg_h;
  } cfg_regs_t;

endpackage

>>> hw/rtl/tmws_if.sv
// ----------------------------------------------------------------------------
// tmws channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------

// command channel
interface tmws_in_if;
  logic                             valid;
  logic                             ready;
  logic [tmws_pkg::CMD_W-1:0]       cmd;
  logic [tmws_pkg::PIX_W-1:0]       pixel_x;
  logic [tmws_pkg::PIX_W-1:0]       pixel_y;
  logic [tmws_pkg::COLOR_W-1:0]     pixel_color;

  modport source (output valid, cmd, pixel_x, pixel_y, pixel_color, input ready);
  modport sink   (input valid, cmd, pixel_x, pixel_y, pixel_color, output ready);
endinterface

// result channel
interface tmws_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [tmws_pkg::COORD_W-1:0] best_x;
  logic signed [tmws_pkg::COORD_W-1:0] best_y;
  logic [tmws_pkg::SCORE_W-1:0]        best_score;
  logic [tmws_pkg::OPAQUE_W-1:0]       opaque_count;

  modport source (output valid, found, best_x, best_y, best_score, opaque_count,
                  input ready);
  modport sink   (input valid, found, best_x, best_y, best_score, opaque_count,
                  output ready);
endinterface

// register write channel
interface tmws_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tmws_pkg::CFG_IDX_W-1:0]    index;
  logic [tmws_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tmws_cfg_regs.sv
// ----------------------------------------------------------------------------
// tmws_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module tmws_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  tmws_cfg_if.sink            cfg_i,
  output tmws_pkg::cfg_regs_t regs_o
);

  tmws_pkg::cfg_regs_t regs_q;
  tmws_pkg::reg_e      idx;

  assign cfg_i.ready = 1'b1;
  assign idx         = tmws_pkg::reg_e'(cfg_i.index);
  assign regs_o      = regs_q;

  // register writes, each value cut to its field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.stride      <= tmws_pkg::STRIDE_RST;
      regs_q.search_size <= tmws_pkg::SEARCH_RST;
      regs_q.origin_x    <= '0;
      regs_q.origin_y    <= '0;
      regs_q.tmpl_w      <= tmws_pkg::TMPL_W_RST;
      regs_q.tmpl_h      <= tmws_pkg::TMPL_H_RST;
      regs_q.bg_w        <= tmws_pkg::BG_W_RST;
      regs_q.bg_h        <= tmws_pkg::BG_H_RST;
    end else if (cfg_i.valid) begin
      unique case (idx)
        tmws_pkg::REG_STRIDE: regs_q.stride      <= cfg_i.data[3:0];
        tmws_pkg::REG_SEARCH: regs_q.search_size <= cfg_i.data[6:0];
        tmws_pkg::REG_ORG_X:  regs_q.origin_x    <= signed'(cfg_i.data[9:0]);
        tmws_pkg::REG_ORG_Y:  regs_q.origin_y    <= signed'(cfg_i.data[9:0]);
        tmws_pkg::REG_TMPL_W: regs_q.tmpl_w      <= cfg_i.data[7:0];
        tmws_pkg::REG_TMPL_H: regs_q.tmpl_h      <= cfg_i.data[7:0];
        tmws_pkg::REG_BG_W:   regs_q.bg_w        <= cfg_i.data[9:0];
        tmws_pkg::REG_BG_H:   regs_q.bg_h        <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/template_match_window_search.sv
// ----------------------------------------------------------------------------
// template_match_window_search
// Exhaustive template search over a square window of offsets.
// ----------------------------------------------------------------------------
// Load commands write one pixel into the background or template store, and
// pixels can stream in back to back while the block is idle. A search
// command walks the stores through their single read ports, one template
// sample per cycle: first a scan of all tw*th template pixels for the
// opaque count (skipped for an empty template), then for each of the
// win*win offsets a walk over the template samples at stride s, closed by
// a read drain, a score multiply and a best compare. Commands are taken
// only while no search runs; a finished result sits in the output register,
// and loads are taken while it waits. Neither store is cleared by reset.

`include "assert_macros.svh"

module template_match_window_search #(
  parameter int BG_MAX_WIDTH    = tmws_pkg::BG_MAX_WIDTH_DEF,
  parameter int BG_MAX_HEIGHT   = tmws_pkg::BG_MAX_HEIGHT_DEF,
  parameter int TMPL_MAX_WIDTH  = tmws_pkg::TMPL_MAX_WIDTH_DEF,
  parameter int TMPL_MAX_HEIGHT = tmws_pkg::TMPL_MAX_HEIGHT_DEF,
  parameter int WINDOW_MAX      = tmws_pkg::WINDOW_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmws_in_if.sink    in_i,
  tmws_out_if.source out_o,
  tmws_cfg_if.sink   cfg_i
);

  // derived sizes
  localparam int TMPL_DEPTH = TMPL_MAX_WIDTH * TMPL_MAX_HEIGHT;
  localparam int BG_DEPTH   = BG_MAX_WIDTH * BG_MAX_HEIGHT;
  localparam int TAW        = $clog2(TMPL_DEPTH);
  localparam int BAW        = $clog2(BG_DEPTH);
  localparam int TXW        = $clog2(TMPL_MAX_WIDTH + 16);
  localparam int TYW        = $clog2(TMPL_MAX_HEIGHT + 16);
  localparam int TXY        = (TXW > TYW) ? TXW : TYW;
  localparam int BXW        = ((TXY > tmws_pkg::COORD_W) ? TXY : tmws_pkg::COORD_W) + 2;
  localparam int WW         = $clog2(WINDOW_MAX + 1);
  localparam int CNTW       = $clog2(TMPL_DEPTH + 1);
  localparam int SCW        = (CNTW + 8 > tmws_pkg::SCORE_W + 1) ?
                              CNTW + 8 : tmws_pkg::SCORE_W + 1;
  localparam int CW         = tmws_pkg::COORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPAQUE,
    S_OFF_INIT,
    S_SAMPLE,
    S_DRAIN,
    S_SCORE,
    S_BEST,
    S_DONE
  } state_e;

  state_e state_q;

  tmws_pkg::cfg_regs_t cfg;

  // configuration registers
  tmws_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (cfg)
  );

  // clamped sizes and sign-extended origin
  logic [TXW-1:0]        tw;
  logic [TYW-1:0]        th;
  logic [WW-1:0]         win;
  logic signed [BXW-1:0] bw;
  logic signed [BXW-1:0] bh;
  logic signed [CW-1:0]  ox;
  logic signed [CW-1:0]  oy;
  logic [3:0]            stride_c;
  logic                  tmpl_empty;

  always_comb begin
    tw = (int'(cfg.tmpl_w) > TMPL_MAX_WIDTH) ? TXW'(TMPL_MAX_WIDTH) : TXW'(cfg.tmpl_w);
    th = (int'(cfg.tmpl_h) > TMPL_MAX_HEIGHT) ? TYW'(TMPL_MAX_HEIGHT) : TYW'(cfg.tmpl_h);
    win = (int'(cfg.search_size) > WINDOW_MAX) ? WW'(WINDOW_MAX) : WW'(cfg.search_size);
    bw = (int'(cfg.bg_w) > BG_MAX_WIDTH) ? BXW'(BG_MAX_WIDTH) : BXW'(cfg.bg_w);
    bh = (int'(cfg.bg_h) > BG_MAX_HEIGHT) ? BXW'(BG_MAX_HEIGHT) : BXW'(cfg.bg_h);
    ox = CW'(cfg.origin_x);
    oy = CW'(cfg.origin_y);
    stride_c = (cfg.stride == 4'd0) ? 4'd1 : cfg.stride;
    tmpl_empty = (tw == '0) || (th == '0);
  end

  // walk registers
  logic [3:0]            stride_q;
  logic [7:0]            sq_q;
  logic [TXW-1:0]        tx_q;
  logic [TYW-1:0]        ty_q;
  logic signed [BXW-1:0] bx_q;
  logic signed [BXW-1:0] by_q;
  logic [WW-1:0]         i_q;
  logic [WW-1:0]         j_q;
  logic signed [CW-1:0]  cx_q;
  logic signed [CW-1:0]  cy_q;
  logic [CNTW-1:0]       count_q;
  logic [CNTW-1:0]       count_d;
  logic [SCW-1:0]        score_q;
  logic [SCW-1:0]        best_q;
  logic signed [CW-1:0]  best_x_q;
  logic signed [CW-1:0]  best_y_q;
  logic                  found_q;
  logic [tmws_pkg::OPAQUE_W-1:0] opaque_q;
  logic [tmws_pkg::OPAQUE_W-1:0] opaque_d;
  logic                  opq_vld_q;
  logic                  smp_vld_q;

  // output register
  logic                          out_vld_q;
  logic                          out_load;
  logic                          out_found_q;
  logic signed [CW-1:0]          out_x_q;
  logic signed [CW-1:0]          out_y_q;
  logic [tmws_pkg::SCORE_W-1:0]  out_score_q;
  logic [tmws_pkg::OPAQUE_W-1:0] out_opaque_q;

  // result moves into the output register once it is free
  assign out_load = (state_q == S_DONE) && (!out_vld_q || out_o.ready);

  // command decode
  logic in_acc;
  logic bg_we;
  logic tmpl_we;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign bg_we      = in_acc && (in_i.cmd == tmws_pkg::CMD_LOAD_BG) &&
                      (int'(in_i.pixel_x) < BG_MAX_WIDTH) &&
                      (int'(in_i.pixel_y) < BG_MAX_HEIGHT);
  assign tmpl_we    = in_acc && (in_i.cmd == tmws_pkg::CMD_LOAD_TMPL) &&
                      (int'(in_i.pixel_x) < TMPL_MAX_WIDTH) &&
                      (int'(in_i.pixel_y) < TMPL_MAX_HEIGHT);

  // store addresses, row-major
  logic [BAW-1:0] bg_waddr;
  logic [BAW-1:0] bg_raddr;
  logic [TAW-1:0] tmpl_waddr;
  logic [TAW-1:0] tmpl_raddr;
  logic           smp_in_bg;

  assign bg_waddr   = BAW'(in_i.pixel_y) * BAW'(BG_MAX_WIDTH) + BAW'(in_i.pixel_x);
  assign tmpl_waddr = TAW'(in_i.pixel_y) * TAW'(TMPL_MAX_WIDTH) + TAW'(in_i.pixel_x);
  assign bg_raddr   = BAW'(unsigned'(by_q)) * BAW'(BG_MAX_WIDTH) + BAW'(unsigned'(bx_q));
  assign tmpl_raddr = TAW'(ty_q) * TAW'(TMPL_MAX_WIDTH) + TAW'(tx_q);
  assign smp_in_bg  = (bx_q >= 0) && (bx_q < bw) && (by_q >= 0) && (by_q < bh);

  // background store
  logic [tmws_pkg::COLOR_W-1:0] bg_mem [BG_DEPTH];
  logic [tmws_pkg::COLOR_W-1:0] bg_rdata_q;

  always_ff @(posedge clk_i) begin
    if (bg_we) begin
      bg_mem[bg_waddr] <= in_i.pixel_color;
    end
    bg_rdata_q <= bg_mem[bg_raddr];
  end

  // template store
  logic [tmws_pkg::COLOR_W-1:0] tmpl_mem [TMPL_DEPTH];
  logic [tmws_pkg::COLOR_W-1:0] tmpl_rdata_q;

  always_ff @(posedge clk_i) begin
    if (tmpl_we) begin
      tmpl_mem[tmpl_waddr] <= in_i.pixel_color;
    end
    tmpl_rdata_q <= tmpl_mem[tmpl_raddr];
  end

  // compare stage on the registered read data; counters clear at offset
  // start and at search start
  always_comb begin
    count_d = count_q;
    if ((state_q == S_OFF_INIT) || (state_q == S_BEST)) begin
      count_d = '0;
    end else if (smp_vld_q && (bg_rdata_q == tmpl_rdata_q)) begin
      count_d = count_q + 1'b1;
    end
    opaque_d = opaque_q;
    if (in_acc && (in_i.cmd == tmws_pkg::CMD_SEARCH)) begin
      opaque_d = '0;
    end else if (opq_vld_q && (tmpl_rdata_q != tmws_pkg::CYAN_KEY) &&
                 (opaque_q != tmws_pkg::OPAQUE_MAX)) begin
      opaque_d = opaque_q + 1'b1;
    end
  end

  // sample stepping: ty inner, tx outer
  logic [TYW-1:0]        ty_step;
  logic [TXW-1:0]        tx_step;
  logic signed [BXW-1:0] stride_x;

  assign ty_step  = ty_q + TYW'(stride_q);
  assign tx_step  = tx_q + TXW'(stride_q);
  assign stride_x = BXW'(stride_q);

  // offset stepping: y inner, x outer
  logic                 off_last;
  logic [WW-1:0]        i_nxt;
  logic [WW-1:0]        j_nxt;
  logic signed [CW-1:0] cx_nxt;
  logic signed [CW-1:0] cy_nxt;

  always_comb begin
    off_last = 1'b0;
    i_nxt    = i_q;
    j_nxt    = j_q + 1'b1;
    cx_nxt   = cx_q;
    cy_nxt   = cy_q + CW'(1);
    if (j_q + 1'b1 >= win) begin
      j_nxt  = '0;
      cy_nxt = oy;
      i_nxt  = i_q + 1'b1;
      cx_nxt = cx_q + CW'(1);
      off_last = (i_q + 1'b1 >= win);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      opq_vld_q <= 1'b0;
      smp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      best_q    <= '0;
    end else begin
      opq_vld_q <= (state_q == S_OPAQUE);
      smp_vld_q <= (state_q == S_SAMPLE) && smp_in_bg;
      count_q   <= count_d;
      opaque_q  <= opaque_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_i.cmd == tmws_pkg::CMD_SEARCH)) begin
            stride_q <= stride_c;
            sq_q     <= 8'(stride_c) * 8'(stride_c);
            best_q   <= '0;
            best_x_q <= '0;
            best_y_q <= '0;
            found_q  <= 1'b0;
            tx_q     <= '0;
            ty_q     <= '0;
            state_q  <= tmpl_empty ? S_OFF_INIT : S_OPAQUE;
          end
        end

        // scan every template pixel for the opaque count
        S_OPAQUE: begin
          if (tx_q + 1'b1 < tw) begin
            tx_q <= tx_q + 1'b1;
          end else begin
            tx_q <= '0;
            if (ty_q + 1'b1 < th) begin
              ty_q <= ty_q + 1'b1;
            end else begin
              state_q <= S_OFF_INIT;
            end
          end
        end

        S_OFF_INIT: begin
          i_q     <= '0;
          j_q     <= '0;
          cx_q    <= ox;
          cy_q    <= oy;
          tx_q    <= '0;
          ty_q    <= '0;
          bx_q    <= BXW'(ox);
          by_q    <= BXW'(oy);
          if (win == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= tmpl_empty ? S_DRAIN : S_SAMPLE;
          end
        end

        // one sampled template pixel per cycle
        S_SAMPLE: begin
          if (ty_step < th) begin
            ty_q <= ty_step;
            by_q <= by_q + stride_x;
          end else begin
            ty_q <= '0;
            by_q <= BXW'(cy_q);
            if (tx_step < tw) begin
              tx_q <= tx_step;
              bx_q <= bx_q + stride_x;
            end else begin
              state_q <= S_DRAIN;
            end
          end
        end

        // last compare lands in count_q
        S_DRAIN: begin
          state_q <= S_SCORE;
        end

        S_SCORE: begin
          score_q <= SCW'(count_q) * SCW'(sq_q);
          state_q <= S_BEST;
        end

        // keep the first strictly higher score, then move to the next offset
        S_BEST: begin
          if (score_q > best_q) begin
            best_q   <= score_q;
            best_x_q <= cx_q;
            best_y_q <= cy_q;
            found_q  <= 1'b1;
          end
          i_q     <= i_nxt;
          j_q     <= j_nxt;
          cx_q    <= cx_nxt;
          cy_q    <= cy_nxt;
          tx_q    <= '0;
          ty_q    <= '0;
          bx_q    <= BXW'(cx_nxt);
          by_q    <= BXW'(cy_nxt);
          if (off_last) begin
            state_q <= S_DONE;
          end else begin
            state_q <= tmpl_empty ? S_DRAIN : S_SAMPLE;
          end
        end

        // hand the result to the output register once it is free
        S_DONE: begin
          if (out_load) begin
            out_found_q  <= found_q;
            out_x_q      <= best_x_q;
            out_y_q      <= best_y_q;
            out_score_q  <= (best_q > SCW'(tmws_pkg::SCORE_MAX)) ?
                            tmws_pkg::SCORE_MAX : tmws_pkg::SCORE_W'(best_q);
            out_opaque_q <= opaque_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.found        = out_found_q;
  assign out_o.best_x       = out_x_q;
  assign out_o.best_y       = out_y_q;
  assign out_o.best_score   = out_score_q;
  assign out_o.opaque_count = out_opaque_q;

  // checks
  `ASSERT_NEVER(a_read_kinds_excl, opq_vld_q && smp_vld_q)
  `ASSERT_PROP(a_sample_in_tmpl, (state_q == S_SAMPLE) |-> ((tx_q < tw) && (ty_q < th)))
  `ASSERT_PROP(a_score_drained, (state_q == S_SCORE) |-> (!smp_vld_q && !opq_vld_q))
  `ASSERT_PROP(a_found_has_score, found_q |-> (best_q != '0))

endmodule

>>> tb/tb_template_match_window_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_template_match_window_search
// Self-checking bench: streams pixel loads and search commands, predicts each
// search result from a shadow copy of both stores and the registers, and
// compares every result transfer field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_template_match_window_search;
  import tmws_pkg::*;

  localparam int          RESET_CYCLES = 12;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          ITEM_TARGET  = 1600;
  localparam int          MIN_SEARCHES = 48;
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [23:0] FILLER       = 24'h5a5a5a;

  // one search outcome
  typedef struct {
    logic                      found;
    logic signed [COORD_W-1:0] best_x;
    logic signed [COORD_W-1:0] best_y;
    logic [SCORE_W-1:0]        score;
    logic [OPAQUE_W-1:0]       opaque;
  } match_result_t;

  // register values after clamping, as the search uses them
  typedef struct {
    int strd;
    int win;
    int tw;
    int th;
    int bw;
    int bh;
    int ox;
    int oy;
  } search_geom_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmws_in_if  in_if ();
  tmws_out_if out_if ();
  tmws_cfg_if cfg_if ();

  template_match_window_search uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow state
  logic [COLOR_W-1:0] bg_mem     [BG_MAX_WIDTH_DEF*BG_MAX_HEIGHT_DEF];
  bit                 bg_written [BG_MAX_WIDTH_DEF*BG_MAX_HEIGHT_DEF];
  logic [COLOR_W-1:0] tmpl_mem     [TMPL_MAX_WIDTH_DEF*TMPL_MAX_HEIGHT_DEF];
  bit                 tmpl_written [TMPL_MAX_WIDTH_DEF*TMPL_MAX_HEIGHT_DEF];
  cfg_regs_t          cfg_model = '{STRIDE_RST, SEARCH_RST, '0, '0,
                                    TMPL_W_RST, TMPL_H_RST, BG_W_RST, BG_H_RST};

  match_result_t pending_matches[$];
  int            mismatches  = 0;
  int            items_taken = 0;
  int            cycle_count = 0;
  int            hold_left   = 0;
  bit            steady_mode = 1'b0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side ready: random stalls, or a counted hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= steady_mode || ($urandom_range(99) >= 8);
    end
  end

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    match_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_matches.size() == 0) begin
        note_failure($sformatf("result with none pending: found %0b at (%0d,%0d)",
                               out_if.found, out_if.best_x, out_if.best_y));
      end else begin
        want = pending_matches.pop_front();
        if (out_if.found !== want.found)
          note_failure($sformatf("found: expected %0b, got %0b", want.found, out_if.found));
        if (out_if.best_x !== want.best_x)
          note_failure($sformatf("best_x: expected %0d, got %0d", want.best_x, out_if.best_x));
        if (out_if.best_y !== want.best_y)
          note_failure($sformatf("best_y: expected %0d, got %0d", want.best_y, out_if.best_y));
        if (out_if.best_score !== want.score)
          note_failure($sformatf("best_score: expected %0d, got %0d", want.score,
                                 out_if.best_score));
        if (out_if.opaque_count !== want.opaque)
          note_failure($sformatf("opaque_count: expected %0d, got %0d", want.opaque,
                                 out_if.opaque_count));
      end
    end
  end

  // clamped, sign-extended view of the registers
  function automatic search_geom_t current_geom();
    search_geom_t g;
    g.strd = (cfg_model.stride == 0) ? 1 : int'(cfg_model.stride);
    g.win  = (cfg_model.search_size > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF
                                                      : int'(cfg_model.search_size);
    g.tw   = (cfg_model.tmpl_w > TMPL_MAX_WIDTH_DEF) ? TMPL_MAX_WIDTH_DEF
                                                     : int'(cfg_model.tmpl_w);
    g.th   = (cfg_model.tmpl_h > TMPL_MAX_HEIGHT_DEF) ? TMPL_MAX_HEIGHT_DEF
                                                      : int'(cfg_model.tmpl_h);
    g.bw   = (cfg_model.bg_w > BG_MAX_WIDTH_DEF) ? BG_MAX_WIDTH_DEF : int'(cfg_model.bg_w);
    g.bh   = (cfg_model.bg_h > BG_MAX_HEIGHT_DEF) ? BG_MAX_HEIGHT_DEF : int'(cfg_model.bg_h);
    g.ox   = int'(cfg_model.origin_x[9:0]) - (cfg_model.origin_x[9] ? 1024 : 0);
    g.oy   = int'(cfg_model.origin_y[9:0]) - (cfg_model.origin_y[9] ? 1024 : 0);
    return g;
  endfunction

  // exhaustive window search over the shadow stores
  function automatic match_result_t score_window();
    search_geom_t  g;
    match_result_t r;
    int best, hits, opaque, cx, cy, px, py, i, j, tx, ty;
    g = current_geom();
    opaque = 0;
    for (i = 0; i < g.th; i++)
      for (j = 0; j < g.tw; j++)
        if (tmpl_mem[i*TMPL_MAX_WIDTH_DEF + j] != CYAN_KEY && opaque < OPAQUE_MAX)
          opaque++;
    best     = 0;
    r.found  = 1'b0;
    r.best_x = '0;
    r.best_y = '0;
    // x outer, y inner; only a strictly higher score replaces the best
    for (i = 0; i < g.win; i++) begin
      for (j = 0; j < g.win; j++) begin
        cx   = g.ox + i;
        cy   = g.oy + j;
        hits = 0;
        for (tx = 0; tx < g.tw; tx += g.strd) begin
          px = cx + tx;
          if (px >= 0 && px < g.bw) begin
            for (ty = 0; ty < g.th; ty += g.strd) begin
              py = cy + ty;
              if (py >= 0 && py < g.bh &&
                  bg_mem[py*BG_MAX_WIDTH_DEF + px] == tmpl_mem[ty*TMPL_MAX_WIDTH_DEF + tx])
                hits++;
            end
          end
        end
        if (hits * g.strd * g.strd > best) begin
          best     = hits * g.strd * g.strd;
          r.found  = 1'b1;
          r.best_x = 11'(cx);
          r.best_y = 11'(cy);
        end
      end
    end
    r.score  = (best > 65535) ? SCORE_MAX : 16'(best);
    r.opaque = 15'(opaque);
    return r;
  endfunction

  // one command transfer; shadow state follows at acceptance
  task automatic send_item(logic [CMD_W-1:0] op, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                           logic [COLOR_W-1:0] color);
    @(negedge clk_i);
    while (!steady_mode && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= op;
    in_if.pixel_x     <= x;
    in_if.pixel_y     <= y;
    in_if.pixel_color <= color;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_taken++;
    case (op)
      CMD_LOAD_BG: begin
        bg_mem[y*BG_MAX_WIDTH_DEF + x]     = color;
        bg_written[y*BG_MAX_WIDTH_DEF + x] = 1'b1;
      end
      CMD_LOAD_TMPL: begin
        // loads beyond the template store are dropped
        if (x < TMPL_MAX_WIDTH_DEF && y < TMPL_MAX_HEIGHT_DEF) begin
          tmpl_mem[y*TMPL_MAX_WIDTH_DEF + x]     = color;
          tmpl_written[y*TMPL_MAX_WIDTH_DEF + x] = 1'b1;
        end
      end
      CMD_SEARCH: begin
        pending_matches = {pending_matches, score_window()};
      end
      default: ;
    endcase
  endtask

  // stop offering, wait for all results, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_STRIDE: cfg_model.stride      = value[3:0];
      REG_SEARCH: cfg_model.search_size = value[6:0];
      REG_ORG_X:  cfg_model.origin_x    = value;
      REG_ORG_Y:  cfg_model.origin_y    = value;
      REG_TMPL_W: cfg_model.tmpl_w      = value[7:0];
      REG_TMPL_H: cfg_model.tmpl_h      = value[7:0];
      REG_BG_W:   cfg_model.bg_w        = value;
      REG_BG_H:   cfg_model.bg_h        = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // all eight registers, written only once the block is idle
  task automatic apply_settings(int stride, int win, int ox, int oy, int tw, int th,
                                int bw, int bh);
    wait_drained();
    write_reg(REG_STRIDE, 10'(stride));
    write_reg(REG_SEARCH, 10'(win));
    write_reg(REG_ORG_X, 10'(ox));
    write_reg(REG_ORG_Y, 10'(oy));
    write_reg(REG_TMPL_W, 10'(tw));
    write_reg(REG_TMPL_H, 10'(th));
    write_reg(REG_BG_W, 10'(bw));
    write_reg(REG_BG_H, 10'(bh));
  endtask

  // small palette so that pixels match often; sometimes any color
  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(7))
      0:       return CYAN_KEY;
      1:       return 24'h000000;
      2:       return 24'hffffff;
      3, 4:    return 24'h3c5a96;
      5:       return 24'h3c5a97;
      default: return 24'($urandom);
    endcase
  endfunction

  // load every store entry the next search can read that is still unwritten
  task automatic fill_for_search(bit use_palette);
    search_geom_t g;
    int x, y, x0, x1, y0, y1;
    g = current_geom();
    for (y = 0; y < g.th; y++)
      for (x = 0; x < g.tw; x++)
        if (!tmpl_written[y*TMPL_MAX_WIDTH_DEF + x])
          send_item(CMD_LOAD_TMPL, 9'(x), 9'(y), use_palette ? pick_color() : FILLER);
    if (g.win > 0 && g.tw > 0 && g.th > 0) begin
      x0 = (g.ox < 0) ? 0 : g.ox;
      y0 = (g.oy < 0) ? 0 : g.oy;
      x1 = g.ox + g.win + g.tw - 2;
      y1 = g.oy + g.win + g.th - 2;
      if (x1 > g.bw - 1) x1 = g.bw - 1;
      if (y1 > g.bh - 1) y1 = g.bh - 1;
      for (y = y0; y <= y1; y++)
        for (x = x0; x <= x1; x++)
          if (!bg_written[y*BG_MAX_WIDTH_DEF + x])
            send_item(CMD_LOAD_BG, 9'(x), 9'(y), use_palette ? pick_color() : FILLER);
    end
  endtask

  // template placed once in the background, unit stride
  task automatic test_basic_match();
    apply_settings(1, 2, 2, 1, 2, 2, 8, 8);
    send_item(CMD_LOAD_TMPL, 9'd0, 9'd0, 24'h000000);
    send_item(CMD_LOAD_TMPL, 9'd1, 9'd0, 24'hffffff);
    send_item(CMD_LOAD_TMPL, 9'd0, 9'd1, CYAN_KEY);
    send_item(CMD_LOAD_TMPL, 9'd1, 9'd1, 24'ha5c3e1);
    send_item(CMD_LOAD_BG, 9'd3, 9'd2, 24'h000000);
    send_item(CMD_LOAD_BG, 9'd4, 9'd2, 24'hffffff);
    send_item(CMD_LOAD_BG, 9'd3, 9'd3, CYAN_KEY);
    send_item(CMD_LOAD_BG, 9'd4, 9'd3, 24'ha5c3e1);
    fill_for_search(1'b0);
    send_item(CMD_SEARCH, '0, '0, '0);
  endtask

  // zero stride, negative offsets, equal scores, dropped commands
  task automatic test_ties_and_ignored();
    apply_settings(0, 3, -1, -1, 2, 1, 3, 3);
    send_item(CMD_LOAD_BG, 9'd0, 9'd0, 24'h000000);
    send_item(CMD_LOAD_BG, 9'd1, 9'd0, 24'h000000);
    // out-of-range template loads alias (1,0) if the address is truncated
    send_item(CMD_LOAD_TMPL, 9'd129, 9'd0, 24'h000000);
    send_item(CMD_LOAD_TMPL, 9'd1, 9'd384, 24'h000000);
    send_item(CMD_UNUSED, 9'd1, 9'd0, 24'h000000);
    fill_for_search(1'b0);
    send_item(CMD_SEARCH, 9'h1ff, 9'h1ff, 24'hffffff);
  endtask

  // nothing matches, empty window, empty template
  task automatic test_no_match();
    apply_settings(1, 2, 2, 1, 2, 2, 8, 8);
    send_item(CMD_LOAD_TMPL, 9'd0, 9'd0, 24'h777777);
    send_item(CMD_LOAD_TMPL, 9'd1, 9'd0, 24'h777777);
    send_item(CMD_LOAD_TMPL, 9'd0, 9'd1, 24'h777777);
    send_item(CMD_LOAD_TMPL, 9'd1, 9'd1, 24'h777777);
    send_item(CMD_SEARCH, '0, '0, '0);
    apply_settings(1, 0, 2, 1, 2, 2, 8, 8);
    send_item(CMD_SEARCH, '0, '0, '0);
    apply_settings(1, 2, 2, 1, 0, 2, 8, 8);
    send_item(CMD_SEARCH, '0, '0, '0);
  endtask

  // register extremes and oversized values that clamp
  task automatic test_extremes();
    apply_settings(15, 127, -60, -60, 1, 1, 3, 3);
    send_item(CMD_LOAD_BG, 9'd2, 9'd1, 24'h000000);
    fill_for_search(1'b0);
    send_item(CMD_SEARCH, '0, '0, '0);
    apply_settings(1, 1, 511, 511, 255, 1, 1023, 1023);
    send_item(CMD_LOAD_BG, 9'd511, 9'd511, 24'h000000);
    fill_for_search(1'b0);
    send_item(CMD_SEARCH, '0, '0, '0);
    apply_settings(15, 2, 0, 0, 1, 200, 1, 1);
    fill_for_search(1'b0);
    send_item(CMD_SEARCH, '0, '0, '0);
    apply_settings(2, 64, -512, -512, 1, 1, 512, 512);
    send_item(CMD_SEARCH, '0, '0, '0);
  endtask

  // result side holds off while searches and loads keep coming
  task automatic test_backpressure();
    apply_settings(1, 2, 0, 0, 2, 2, 8, 8);
    fill_for_search(1'b0);
    hold_left = HOLD_CYCLES;
    send_item(CMD_SEARCH, '0, '0, '0);
    send_item(CMD_LOAD_BG, 9'd1, 9'd1, 24'hffffff);
    send_item(CMD_SEARCH, '0, '0, '0);
    send_item(CMD_LOAD_TMPL, 9'd0, 9'd0, 24'hffffff);
    send_item(CMD_SEARCH, '0, '0, '0);
    wait_drained();
  endtask

  // random settings, random loads around the window, then searches
  task automatic test_random_traffic();
    int stride, win, ox, oy, tw, th, bw, bh;
    int base_x, base_y, px, py, first_item, searches, iter;
    first_item = items_taken;
    searches   = 0;
    iter       = 0;
    while (items_taken - first_item < ITEM_TARGET || searches < MIN_SEARCHES) begin
      steady_mode = (iter >= 20 && iter < 32);
      if (iter % 4 == 0) begin
        stride = $urandom_range(0, 15);
        win    = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        tw     = $urandom_range(0, 10);
        th     = $urandom_range(0, 10);
        case ($urandom_range(5))
          0: begin
            // far corner of a large background
            ox = $urandom_range(498, 511);
            oy = $urandom_range(498, 511);
            bw = $urandom_range(500, 1023);
            bh = $urandom_range(500, 1023);
          end
          1: begin
            ox = $urandom_range(0, 8) - 512;
            oy = $urandom_range(0, 20) - 10;
            bw = $urandom_range(1, 600);
            bh = $urandom_range(1, 24);
          end
          default: begin
            ox = $urandom_range(0, 24) - 6;
            oy = $urandom_range(0, 24) - 6;
            bw = $urandom_range(1, 24);
            bh = $urandom_range(1, 24);
          end
        endcase
        apply_settings(stride, win, ox, oy, tw, th, bw, bh);
      end else if ($urandom_range(5) == 0) begin
        wait_drained();
      end
      base_x = (ox < 0) ? 0 : ox;
      base_y = (oy < 0) ? 0 : oy;
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5: begin
            px = base_x + $urandom_range(0, 14);
            py = base_y + $urandom_range(0, 14);
            if (px > 511) px = 511;
            if (py > 511) py = 511;
            send_item(CMD_LOAD_BG, 9'(px), 9'(py), pick_color());
          end
          6, 7, 8, 9:
            send_item(CMD_LOAD_TMPL, 9'($urandom_range(0, 11)), 9'($urandom_range(0, 11)),
                      pick_color());
          10, 11, 12, 13:
            send_item(CMD_LOAD_BG, 9'($urandom), 9'($urandom), 24'($urandom));
          14, 15, 16:
            send_item(CMD_LOAD_TMPL, 9'($urandom), 9'($urandom), 24'($urandom));
          default:
            send_item(CMD_UNUSED, 9'($urandom), 9'($urandom), 24'($urandom));
        endcase
      end
      fill_for_search(1'b1);
      send_item(CMD_SEARCH, 9'($urandom), 9'($urandom), 24'($urandom));
      searches++;
      // back-to-back search while the previous result may still wait
      if ($urandom_range(3) == 0) begin
        send_item(CMD_SEARCH, 9'($urandom), 9'($urandom), 24'($urandom));
        searches++;
      end
      iter++;
    end
    steady_mode = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = '0;
    in_if.pixel_x     = '0;
    in_if.pixel_y     = '0;
    in_if.pixel_color = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_match();
    test_ties_and_ignored();
    test_no_match();
    test_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
